/* src/dcb_pkg.sv */
// Package for the multichannel DC blocking filter.
// Sample widths, register indexes, format codes and reset values.
// No dependencies.
`default_nettype none

package dcb_pkg;

	localparam int MAX_CHANNELS = 4;
	localparam int CH_W         = $clog2(MAX_CHANNELS);
	localparam int SAMPLE_W     = 32;
	localparam int CFG_IDX_W    = 3;
	localparam int FMT_W        = 2;
	localparam int CNT_W        = 3;

	localparam logic [CFG_IDX_W-1:0] REG_FORMAT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CH_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEFF_0  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEFF_1  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEFF_2  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COEFF_3  = 3'd5;

	localparam logic [FMT_W-1:0] FMT_16 = 2'd0;
	localparam logic [FMT_W-1:0] FMT_24 = 2'd1;
	localparam logic [FMT_W-1:0] FMT_32 = 2'd2;

	localparam logic [CNT_W-1:0] CH_COUNT_RESET = 3'd2;
	localparam logic signed [SAMPLE_W-1:0] COEFF_RESET = 32'sd1052266987;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

`default_nettype wire

/* src/multichannel_dc_blocking_filter_top.sv */
// Multichannel DC blocking filter, y = x - x_prev + R * y_prev per channel.
// Input register, one-pass filter datapath, output register.
// Depends on dcb_pkg.
//
//  channel   | dir | handshake                     | payload
//  ----------+-----+-------------------------------+---------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata[31:0] = sample_in
//  m_axis    | out | m_axis_tvalid / m_axis_tready | tdata[31:0] = sample_out
//  cfg       | in  | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// One sample per cycle sustained while the output is not stalled. The 32x32
// multiply, add and saturate of one sample sit in a single stage, so a
// channel's y_prev is ready for its next sample.
// Reset restores configuration and clears all channel history; cfg_ready stays high.
// A stalled output holds the input register, which then drops s_axis_tready.
`default_nettype none

module multichannel_dc_blocking_filter_top
	import dcb_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [SAMPLE_W-1:0]  s_axis_tdata,   // [31:0] sample_in
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [SAMPLE_W-1:0]       m_axis_tdata,   // [31:0] sample_out
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SAMPLE_W-1:0]  cfg_data
);

	logic [FMT_W-1:0] fmt_q;
	logic [CNT_W-1:0] ch_count_q;
	sample_t          coeff_q [MAX_CHANNELS];
	sample_t          prev_in_q [MAX_CHANNELS];
	sample_t          prev_out_q [MAX_CHANNELS];
	logic [CH_W-1:0]  ch_idx_q;

	logic             valid_s1;
	sample_t          sample_s1;
	logic             out_valid_q;
	logic [SAMPLE_W-1:0] out_data_q;

	logic             adv;
	logic             cfg_wr;
	logic [CNT_W-1:0] nch;
	logic [CH_W-1:0]  ch;
	logic [CNT_W-1:0] ch_inc;
	logic [CH_W-1:0]  ch_next;

	sample_t                x;
	logic signed [63:0]     prod;
	logic signed [35:0]     prod_rnd;
	logic signed [35:0]     sum;
	sample_t                y;
	logic signed [17:0]     r16_a;
	logic signed [16:0]     r16_b;
	logic signed [15:0]     r16;
	logic signed [25:0]     r24_a;
	logic signed [24:0]     r24_b;
	logic signed [23:0]     r24;
	logic [SAMPLE_W-1:0]    res;

	assign cfg_ready     = 1'b1;
	assign cfg_wr        = cfg_valid & cfg_ready;
	assign adv           = valid_s1 & (~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | adv;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// channel selection
	always_comb begin
		if (ch_count_q == '0)
			nch = CNT_W'(1);
		else if (ch_count_q > CNT_W'(MAX_CHANNELS))
			nch = CNT_W'(MAX_CHANNELS);
		else
			nch = ch_count_q;
		ch      = ({1'b0, ch_idx_q} >= nch) ? '0 : ch_idx_q;
		ch_inc  = {1'b0, ch} + CNT_W'(1);
		ch_next = (ch_inc >= nch) ? '0 : ch_inc[CH_W-1:0];
	end

	// filter datapath
	always_comb begin
		case (fmt_q)
			FMT_16:  x = {sample_s1[15:0], 16'h0000};
			FMT_24:  x = {sample_s1[23:0], 8'h00};
			default: x = sample_s1;
		endcase

		prod     = coeff_q[ch] * prev_out_q[ch];
		prod_rnd = {prod[63], prod[63:29]} + 36'sd1;
		sum      = 36'(x) - 36'(prev_in_q[ch]) + {prod_rnd[35], prod_rnd[35:1]};
		if (sum[35:31] != {5{sum[31]}})
			y = sum[35] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		else
			y = sum[31:0];

		r16_a = {y[31], y[31:15]} + 18'sd1;
		r16_b = r16_a[17:1];
		if (r16_b[16] != r16_b[15])
			r16 = r16_b[16] ? 16'sh8000 : 16'sh7fff;
		else
			r16 = r16_b[15:0];

		r24_a = {y[31], y[31:7]} + 26'sd1;
		r24_b = r24_a[25:1];
		if (r24_b[24] != r24_b[23])
			r24 = r24_b[24] ? 24'sh80_0000 : 24'sh7f_ffff;
		else
			r24 = r24_b[23:0];

		case (fmt_q)
			FMT_16:  res = 32'(r16);
			FMT_24:  res = 32'(r24);
			default: res = y;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (adv)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready & s_axis_tvalid)
			sample_s1 <= s_axis_tdata;
		if (adv)
			out_data_q <= res;
	end

	// channel state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q      <= FMT_32;
			ch_count_q <= CH_COUNT_RESET;
			ch_idx_q   <= '0;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				coeff_q[i]    <= COEFF_RESET;
				prev_in_q[i]  <= '0;
				prev_out_q[i] <= '0;
			end
		end else begin
			if (adv) begin
				prev_in_q[ch]  <= x;
				prev_out_q[ch] <= y;
				ch_idx_q       <= ch_next;
			end
			if (cfg_wr) begin
				case (cfg_index)
					REG_FORMAT:   fmt_q <= cfg_data[FMT_W-1:0];
					REG_CH_COUNT: begin
						ch_count_q <= cfg_data[CNT_W-1:0];
						ch_idx_q   <= '0;
					end
					REG_COEFF_0:  coeff_q[0] <= cfg_data;
					REG_COEFF_1:  coeff_q[1] <= cfg_data;
					REG_COEFF_2:  coeff_q[2] <= cfg_data;
					REG_COEFF_3:  coeff_q[3] <= cfg_data;
					default:      ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

/* src/dcb_checker.sv */
// Port-level checker for the multichannel DC blocking filter, with its bind.
// Depends on dcb_pkg and multichannel_dc_blocking_filter_top.
`default_nettype none

module dcb_checker
	import dcb_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_axis_tvalid,
	input wire logic                 s_axis_tready,
	input wire logic                 m_axis_tvalid,
	input wire logic                 m_axis_tready,
	input wire logic [SAMPLE_W-1:0]  m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output transfer dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output data changed while stalled");

	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid || m_axis_tready |-> s_axis_tready)
		else $error("input stalled with free output");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
		else $error("input transfer produced no result");

endmodule

bind multichannel_dc_blocking_filter_top dcb_checker u_dcb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
